/* hw/rtl/box_average_downsample_core_defines.svh */
// ----------------------------------------------------------------------------
// Box average downsampler: assertion macros
// Shared property wrappers for the concurrent checks in the core.
// ----------------------------------------------------------------------------
`ifndef BOX_AVERAGE_DOWNSAMPLE_CORE_DEFINES_SVH
`define BOX_AVERAGE_DOWNSAMPLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BADS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bads: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define BADS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bads: next-cycle check failed");

`endif

/* hw/rtl/bads_pkg.sv */
// ----------------------------------------------------------------------------
// Box average downsampler package
// Widths, register indexes, handshake structs and clamp helpers.
// ----------------------------------------------------------------------------
package bads_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_BOX        = 16;
    localparam int SAMPLE_BITS    = 32;
    localparam int SUM_BITS       = 40;
    localparam int COL_BITS       = 12;
    localparam int DIM_BITS       = 13;
    localparam int BOX_BITS       = 5;
    localparam int BIN_BITS       = 4;
    localparam int CNT_BITS       = 9;
    localparam int TALLY_BITS     = 25;
    localparam int DIV_STEPS      = SUM_BITS;
    localparam int DSTEP_BITS     = 6;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int OUT_FIELD_BITS = SAMPLE_BITS + 2 * COL_BITS + TALLY_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IN_WIDTH   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IN_HEIGHT  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MISSING    = 3'd4;

    localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take a sample, snapshot position, issue row-store read
        logic acc;      // accumulate and write back
        logic step;     // one divider iteration
        logic load;     // fill the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic emit;      // the accumulated sample closes a box
        logic div_done;  // final divider iteration this cycle
        logic out_free;  // output register can take a result
    } t_status;

    function automatic logic [BOX_BITS-1:0] clamp_box(input logic [BOX_BITS-1:0] v);
        logic [BOX_BITS-1:0] r;
        if (v == '0) begin
            r = BOX_BITS'(1);
        end else if (v > BOX_BITS'(MAX_BOX)) begin
            r = BOX_BITS'(MAX_BOX);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (v > DIM_BITS'(MAX_WIDTH)) begin
            r = DIM_BITS'(MAX_WIDTH);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/bads_ctrl.sv */
// ----------------------------------------------------------------------------
// Box average downsampler controller
// Sequences accept, accumulate, divide and output load for one sample.
// ----------------------------------------------------------------------------
module bads_ctrl
    import bads_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // take nothing while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // hold until the output register drains
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/bads_dpath.sv */
// ----------------------------------------------------------------------------
// Box average downsampler datapath
// Config registers, position counters, row store, serial divider, output reg.
// ----------------------------------------------------------------------------
module bads_dpath
    import bads_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic                      i_m_tready,
    output logic                      o_m_tvalid,
    output logic [OUT_TDATA_BITS-1:0] o_m_tdata,
    output logic                      o_m_tuser,
    output logic                      o_m_tlast
);

    // configuration
    logic [BOX_BITS-1:0]    r_box_w, r_box_h;
    logic [DIM_BITS-1:0]    r_in_w, r_in_h;
    logic [SAMPLE_BITS-1:0] r_missing;
    logic                   cfg_hit;

    // position of the next sample
    logic [COL_BITS-1:0] r_col, r_row, r_out_col, r_out_row;
    logic [BIN_BITS-1:0] r_cib, r_rib;
    logic [TALLY_BITS-1:0] r_tally;

    // per-sample snapshot
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [COL_BITS-1:0]    r_s_col, r_s_row;
    logic                   r_first, r_emit, r_last;
    logic [CNT_BITS-1:0]    r_div;

    // row store
    logic [SUM_BITS-1:0] r_mem [MAX_WIDTH];
    logic [SUM_BITS-1:0] r_rd;
    logic [SUM_BITS-1:0] n_sum;

    // divider
    logic [SUM_BITS-1:0]   r_quo;
    logic [CNT_BITS-1:0]   r_rem;
    logic                  r_neg;
    logic [DSTEP_BITS-1:0] r_step;
    logic [CNT_BITS:0]     rem_sh;
    logic                  rem_ge;

    // output register
    logic                   r_ovalid;
    logic [SAMPLE_BITS-1:0] r_o_avg;
    logic [COL_BITS-1:0]    r_o_col, r_o_row;
    logic                   r_o_miss, r_o_last;
    logic [TALLY_BITS-1:0]  r_o_count;

    // clamped settings and position decode
    logic [BOX_BITS-1:0] bw, bh, ncols, nrows;
    logic [DIM_BITS-1:0] w, h, rem_cols, rem_rows;
    logic                col_last, row_last, cib_end, rib_end;
    logic                col_end, row_end, field_end;
    logic [SUM_BITS-1:0] quo_signed;
    logic [SAMPLE_BITS-1:0] avg;
    logic                miss;
    logic [TALLY_BITS-1:0] n_tally;

    assign bw = clamp_box(r_box_w);
    assign bh = clamp_box(r_box_h);
    assign w  = clamp_dim(r_in_w);
    assign h  = clamp_dim(r_in_h);

    assign col_last  = ({1'b0, r_col} == (w - DIM_BITS'(1)));
    assign row_last  = ({1'b0, r_row} == (h - DIM_BITS'(1)));
    assign cib_end   = ({1'b0, r_cib} == (bw - BOX_BITS'(1)));
    assign rib_end   = ({1'b0, r_rib} == (bh - BOX_BITS'(1)));
    assign col_end   = cib_end || col_last;
    assign row_end   = rib_end || row_last;
    assign field_end = col_last && row_last;

    // samples left from the box's first column / band's first row to the edge
    assign rem_cols = w - {1'b0, r_col} + DIM_BITS'(r_cib);
    assign rem_rows = h - {1'b0, r_row} + DIM_BITS'(r_rib);
    assign ncols    = (rem_cols > DIM_BITS'(bw)) ? bw : rem_cols[BOX_BITS-1:0];
    assign nrows    = (rem_rows > DIM_BITS'(bh)) ? bh : rem_rows[BOX_BITS-1:0];

    assign cfg_hit = i_cfg_we && (i_cfg_addr == REG_BOX_WIDTH  ||
                                  i_cfg_addr == REG_BOX_HEIGHT ||
                                  i_cfg_addr == REG_IN_WIDTH   ||
                                  i_cfg_addr == REG_IN_HEIGHT  ||
                                  i_cfg_addr == REG_MISSING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w   <= BOX_BITS'(1);
            r_box_h   <= BOX_BITS'(1);
            r_in_w    <= DIM_BITS'(MAX_WIDTH);
            r_in_h    <= DIM_BITS'(MAX_WIDTH);
            r_missing <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BOX_WIDTH:  r_box_w   <= i_cfg_data[BOX_BITS-1:0];
                REG_BOX_HEIGHT: r_box_h   <= i_cfg_data[BOX_BITS-1:0];
                REG_IN_WIDTH:   r_in_w    <= i_cfg_data[DIM_BITS-1:0];
                REG_IN_HEIGHT:  r_in_h    <= i_cfg_data[DIM_BITS-1:0];
                REG_MISSING:    r_missing <= i_cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // position counters: advance on every accepted sample, restart on config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col     <= '0;
            r_row     <= '0;
            r_cib     <= '0;
            r_rib     <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cmd.accept) begin
            if (field_end) begin
                r_col     <= '0;
                r_row     <= '0;
                r_cib     <= '0;
                r_rib     <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (col_last) begin
                r_col     <= '0;
                r_cib     <= '0;
                r_out_col <= '0;
                r_row     <= r_row + COL_BITS'(1);
                if (rib_end) begin
                    r_rib     <= '0;
                    r_out_row <= r_out_row + COL_BITS'(1);
                end else begin
                    r_rib <= r_rib + BIN_BITS'(1);
                end
            end else begin
                r_col <= r_col + COL_BITS'(1);
                if (cib_end) begin
                    r_cib     <= '0;
                    r_out_col <= r_out_col + COL_BITS'(1);
                end else begin
                    r_cib <= r_cib + BIN_BITS'(1);
                end
            end
        end
    end

    // snapshot of the accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (i_cmd.accept) begin
            r_emit <= col_end && row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_s_col  <= r_out_col;
            r_s_row  <= r_out_row;
            r_first  <= (r_cib == '0) && (r_rib == '0);
            r_last   <= field_end;
            r_div    <= CNT_BITS'(ncols) * CNT_BITS'(nrows);
        end
    end

    // row store: read on accept, write back in the following cycle
    assign n_sum = r_first ? SUM_BITS'(signed'(r_sample))
                           : r_rd + SUM_BITS'(signed'(r_sample));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[r_out_col];
        end
        if (i_cmd.acc) begin
            r_mem[r_s_col] <= n_sum;
        end
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[SUM_BITS-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.acc) begin
            r_step <= '0;
        end else if (i_cmd.step) begin
            r_step <= r_step + DSTEP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_neg <= n_sum[SUM_BITS-1];
            r_quo <= n_sum[SUM_BITS-1] ? (~n_sum + SUM_BITS'(1)) : n_sum;
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[SUM_BITS-2:0], rem_ge};
            r_rem <= rem_ge ? CNT_BITS'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_BITS-1:0];
        end
    end

    assign quo_signed = r_neg ? (~r_quo + SUM_BITS'(1)) : r_quo;
    assign avg        = quo_signed[SAMPLE_BITS-1:0];
    assign miss       = (avg == r_missing);
    assign n_tally    = (miss && (r_tally != TALLY_MAX)) ? r_tally + TALLY_BITS'(1) : r_tally;

    // missing tally: restart on config and after the final output of a field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_tally <= '0;
        end else if (i_cmd.load) begin
            r_tally <= r_last ? '0 : n_tally;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_avg   <= avg;
            r_o_col   <= r_s_col;
            r_o_row   <= r_s_row;
            r_o_miss  <= miss;
            r_o_count <= n_tally;
            r_o_last  <= r_last;
        end
    end

    assign o_status.emit     = r_emit;
    assign o_status.div_done = (r_step == DSTEP_BITS'(DIV_STEPS - 1));
    assign o_status.out_free = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_TDATA_BITS'({r_o_count, r_o_row, r_o_col, r_o_avg});
    assign o_m_tuser  = r_o_miss;
    assign o_m_tlast  = r_o_last;

endmodule

/* hw/rtl/box_average_downsample_core.sv */
// ----------------------------------------------------------------------------
// Box average downsampler core
// Averages each box of a row-major field into one sample of a reduced field.
// ----------------------------------------------------------------------------
// Samples enter on the slave stream (i_s_*), one Q16.16 value per transaction,
// in row-major order. One result leaves on the master stream (o_m_*) whenever
// a sample completes a box; edge boxes are divided by their true sample count.
// Settings must be written through i_cfg_we / i_cfg_addr / i_cfg_data only
// while the block is idle; the block itself does not enforce this. A write to
// any of the five registers restarts the field and the missing tally. A sample
// that closes no box is accepted, then its row-store entry is read, summed
// and written back. A sample that closes a box then also passes through the
// bit-serial divider and is loaded into the output register. No new sample
// is taken until the controller has returned to idle after the previous one.
// Reset returns the settings to their defaults and clears positions, tally
// and the output register; the row store is not cleared, as every entry is
// written by the first sample of its box before it is read.
// A stalled receiver holds the result in the output register; the next
// sample is still taken, and its result waits until the register drains.
// ----------------------------------------------------------------------------
`include "box_average_downsample_core_defines.svh"

module box_average_downsample_core
    import bads_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // sample stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [SAMPLE_BITS-1:0]    i_s_tdata,   // [31:0] sample
    // result stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_tdata,   // [31:0] average, [43:32] out_col,
                                                   // [55:44] out_row,
                                                   // [80:56] missing_count, rest zero
    output logic                      o_m_tuser,   // [0] is_missing
    output logic                      o_m_tlast
);

    t_cmd    cmd;
    t_status status;

    bads_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bads_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_s_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    `BADS_ASSERT_IMPL(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0({cmd.accept, cmd.acc, cmd.step, cmd.load}))
    `BADS_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, cmd.load, status.out_free)
    `BADS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `BADS_ASSERT_IMPL(a_miss_counted, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata[80:56] != '0)

endmodule

/* tb/sv/tb_box_average_downsample_core.sv */
// ----------------------------------------------------------------------------
// Box average downsampler core testbench
// Streams row-major fields into the core, predicts every box mean, its
// reduced-field position, the missing flag, the running tally and the end of
// field marker, and checks each result transaction in order against that
// prediction. A short table covers extremes, truncation and size clamping;
// random phases follow with new settings, mostly whole fields, source gaps,
// random back-pressure on the result stream and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_box_average_downsample_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bads_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 48;
    localparam int unsigned TAIL_CYCLES   = 60;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned HOLD_PHASE    = 1;
    localparam int unsigned CALM_PHASE    = 2;
    localparam int unsigned CALM_ITEMS    = 200;
    localparam int unsigned RANDOM_ITEMS  = 1300;

    localparam int COL_LSB = SAMPLE_BITS;
    localparam int ROW_LSB = COL_LSB + COL_BITS;
    localparam int CNT_LSB = ROW_LSB + COL_BITS;
    localparam int PAD_LSB = CNT_LSB + TALLY_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = {CFG_ADDR_BITS{1'b1}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic [COL_BITS-1:0]    out_col;
        logic [COL_BITS-1:0]    out_row;
        logic                   is_missing;
        logic [TALLY_BITS-1:0]  missing_count;
        logic                   last;
    } box_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_SETTING} row_kind_e;

    typedef struct {
        row_kind_e                kind;
        logic [CFG_ADDR_BITS-1:0] addr;
        logic [CFG_DATA_BITS-1:0] data;
        bit                       typed;
        box_result_t              want;
    } stim_row_t;

    logic                      i_clk;
    logic                      i_rst_n    = 1'b0;
    logic                      i_cfg_we   = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [SAMPLE_BITS-1:0]    i_s_tdata  = '0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;
    logic                      o_m_tuser;
    logic                      o_m_tlast;

    // predictor copy of the settings and of the block state
    int unsigned            set_box_w   = 1;
    int unsigned            set_box_h   = 1;
    int unsigned            set_field_w = MAX_WIDTH;
    int unsigned            set_field_h = MAX_WIDTH;
    logic [SAMPLE_BITS-1:0] set_missing = '0;
    longint                 box_acc [MAX_WIDTH];
    int unsigned            pos_col     = 0;
    int unsigned            pos_row     = 0;
    int unsigned            miss_tally  = 0;

    box_result_t pending_averages [$];
    int unsigned n_errors      = 0;
    int unsigned cycle_count   = 0;
    bit          calm          = 1'b0;
    bit          hold_request  = 1'b0;

    box_average_downsample_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic void restart_field();
        pos_col    = 0;
        pos_row    = 0;
        miss_tally = 0;
    endfunction

    // Accumulate one sample into its box; return 1 with the mean when the box closes
    function automatic bit predict_box_average(input logic [SAMPLE_BITS-1:0] smp,
                                               output box_result_t res);
        int unsigned bw, bh, fw, fh, col, row, slot, col0, row0, ncols, nrows;
        longint      mean;
        bit          col_end, row_end, field_end, miss;
        bw   = clip_size(set_box_w, MAX_BOX);
        bh   = clip_size(set_box_h, MAX_BOX);
        fw   = clip_size(set_field_w, MAX_WIDTH);
        fh   = clip_size(set_field_h, MAX_WIDTH);
        col  = (pos_col >= fw) ? fw - 1 : pos_col;
        row  = (pos_row >= fh) ? fh - 1 : pos_row;
        slot = (col / bw) % MAX_WIDTH;
        col0 = col - col % bw;
        row0 = row - row % bh;
        res  = '0;
        // the first sample of a box in the band's first row overwrites the entry
        if (row == row0 && col == col0) begin
            box_acc[slot] = longint'($signed(smp));
        end else begin
            box_acc[slot] += longint'($signed(smp));
        end
        col_end   = (col % bw == bw - 1) || (col == fw - 1);
        row_end   = (row % bh == bh - 1) || (row == fh - 1);
        field_end = (col == fw - 1) && (row == fh - 1);
        if (col == fw - 1) begin
            pos_col = 0;
            pos_row = row + 1;
        end else begin
            pos_col = col + 1;
            pos_row = row;
        end
        if (!(col_end && row_end)) begin
            return 1'b0;
        end
        ncols = (fw - col0 > bw) ? bw : fw - col0;
        nrows = (fh - row0 > bh) ? bh : fh - row0;
        mean  = box_acc[slot] / longint'(ncols * nrows);
        miss  = (mean == longint'($signed(set_missing)));
        if (miss && miss_tally < TALLY_MAX) begin
            miss_tally++;
        end
        res.average       = mean[SAMPLE_BITS-1:0];
        res.out_col       = COL_BITS'(col / bw);
        res.out_row       = COL_BITS'(row / bh);
        res.is_missing    = miss;
        res.missing_count = TALLY_BITS'(miss_tally);
        res.last          = field_end;
        if (field_end) begin
            restart_field();
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t row_set(input logic [CFG_ADDR_BITS-1:0] addr,
                                          input logic [CFG_DATA_BITS-1:0] data);
        stim_row_t r;
        r      = '{kind: ROW_SETTING, addr: addr, data: data, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t row_smp(input logic [SAMPLE_BITS-1:0] data);
        stim_row_t r;
        r      = '{kind: ROW_SAMPLE, addr: '0, data: data, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t row_chk(input logic [SAMPLE_BITS-1:0] data,
                                          input logic [SAMPLE_BITS-1:0] avg,
                                          input int unsigned col, input int unsigned row,
                                          input bit miss, input int unsigned cnt,
                                          input bit last);
        stim_row_t r;
        r = row_smp(data);
        r.typed              = 1'b1;
        r.want.average       = avg;
        r.want.out_col       = COL_BITS'(col);
        r.want.out_row       = COL_BITS'(row);
        r.want.is_missing    = miss;
        r.want.missing_count = TALLY_BITS'(cnt);
        r.want.last          = last;
        return r;
    endfunction

    function automatic int unsigned pick_box();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(1, MAX_BOX);
        end
        return $urandom_range(1) ? 0 : $urandom_range(MAX_BOX + 1, (1 << BOX_BITS) - 1);
    endfunction

    function automatic int unsigned pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) begin
            return $urandom_range(1, 24);
        end else if (r < 86) begin
            return 0;
        end else if (r < 93) begin
            return MAX_WIDTH;
        end
        return $urandom_range(MAX_WIDTH + 1, (1 << DIM_BITS) - 1);
    endfunction

    // set junk above the register field now and then; the block must ignore it
    function automatic logic [CFG_DATA_BITS-1:0] with_noise(input int unsigned v,
                                                            input int unsigned bits);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = $urandom_range(1) ? ($urandom() << bits) : '0;
        return junk | CFG_DATA_BITS'(v);
    endfunction

    // Registers are only written while the block is idle
    task automatic write_setting(input logic [CFG_ADDR_BITS-1:0] addr,
                                 input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (addr)
            REG_BOX_WIDTH:  set_box_w   = data[BOX_BITS-1:0];
            REG_BOX_HEIGHT: set_box_h   = data[BOX_BITS-1:0];
            REG_IN_WIDTH:   set_field_w = data[DIM_BITS-1:0];
            REG_IN_HEIGHT:  set_field_h = data[DIM_BITS-1:0];
            REG_MISSING:    set_missing = data[SAMPLE_BITS-1:0];
            default: ;
        endcase
        if (addr <= REG_MISSING) begin
            restart_field();
        end
    endtask

    // Offer one sample until taken, then queue what it is expected to produce
    task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp, input bit typed,
                               input box_result_t want);
        box_result_t res;
        bit          has_res;
        while (!calm && $urandom_range(99) < 19) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp;
        do @(posedge i_clk); while (!o_s_tready);
        has_res = predict_box_average(smp, res);
        if (typed) begin
            pending_averages.push_back(want);
        end else if (has_res) begin
            pending_averages.push_back(res);
        end
    endtask

    task automatic drain_block(input int unsigned extra);
        i_s_tvalid <= 1'b0;
        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_average();
        box_result_t want;
        if (pending_averages.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, got %h",
                     $time, o_m_tdata);
            n_errors++;
            return;
        end
        want = pending_averages.pop_front();
        check_field("average", 64'(want.average), 64'(o_m_tdata[0 +: SAMPLE_BITS]));
        check_field("out_col", 64'(want.out_col), 64'(o_m_tdata[COL_LSB +: COL_BITS]));
        check_field("out_row", 64'(want.out_row), 64'(o_m_tdata[ROW_LSB +: COL_BITS]));
        check_field("missing_count", 64'(want.missing_count),
                    64'(o_m_tdata[CNT_LSB +: TALLY_BITS]));
        check_field("tdata padding", 64'd0, 64'(o_m_tdata[OUT_TDATA_BITS-1:PAD_LSB]));
        check_field("is_missing", 64'(want.is_missing), 64'(o_m_tuser));
        check_field("last", 64'(want.last), 64'(o_m_tlast));
    endtask

    // Result side: check each transaction, stall at random or on request
    initial begin : result_sink
        int unsigned held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                check_average();
            end
            if (hold_request) begin
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_request = 1'b0;
                    held         = 0;
                end
            end
            i_m_tready <= !hold_request && (calm || $urandom_range(99) >= 19);
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin : stimulus
        stim_row_t              dir_rows [$];
        int unsigned            phase, n_random, bw, bh, fw, fh, area, nitems;
        logic [SAMPLE_BITS-1:0] mv_val, smp;
        bit                     flat;

        // after reset: 1x1 boxes, every sample is its own mean, missing value zero
        dir_rows.push_back(row_chk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b0, 0, 1'b0));
        dir_rows.push_back(row_chk(32'h8000_0000, 32'h8000_0000, 1, 0, 1'b0, 0, 1'b0));
        dir_rows.push_back(row_chk(32'h0000_0000, 32'h0000_0000, 2, 0, 1'b1, 1, 1'b0));
        dir_rows.push_back(row_chk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 0, 1'b0, 1, 1'b0));
        // 3x3 field in 2x2 boxes: partial edge boxes, negative sum truncates to zero
        dir_rows.push_back(row_set(REG_BOX_WIDTH, 32'd2));
        dir_rows.push_back(row_set(REG_BOX_HEIGHT, 32'd2));
        dir_rows.push_back(row_set(REG_IN_WIDTH, 32'd3));
        dir_rows.push_back(row_set(REG_IN_HEIGHT, 32'd3));
        dir_rows.push_back(row_set(REG_MISSING, 32'hFFFF_0000));
        dir_rows.push_back(row_smp(32'hFFFF_FFFF));
        dir_rows.push_back(row_smp(32'hFFFF_FFFF));
        dir_rows.push_back(row_smp(32'h0000_0005));
        dir_rows.push_back(row_smp(32'hFFFF_FFFF));
        dir_rows.push_back(row_smp(32'h0000_0000));
        dir_rows.push_back(row_smp(32'h0000_0006));
        dir_rows.push_back(row_smp(32'hFFFF_0000));
        dir_rows.push_back(row_smp(32'hFFFF_0000));
        dir_rows.push_back(row_smp(32'hFFFF_0000));
        // clamped sizes: box 31 wide, 0 high; field 0 wide, 2 high
        dir_rows.push_back(row_set(REG_BOX_WIDTH, 32'hFFFF_FFFF));
        dir_rows.push_back(row_set(REG_BOX_HEIGHT, 32'hFFFF_FFE0));
        dir_rows.push_back(row_set(REG_IN_WIDTH, 32'hFFFF_E000));
        dir_rows.push_back(row_set(REG_IN_HEIGHT, 32'd2));
        dir_rows.push_back(row_chk(32'h1234_5678, 32'h1234_5678, 0, 0, 1'b0, 0, 1'b0));
        // unused register index: no restart, the field carries on
        dir_rows.push_back(row_set(REG_UNUSED, 32'hDEAD_BEEF));
        dir_rows.push_back(row_chk(32'hEDCB_A988, 32'hEDCB_A988, 0, 1, 1'b0, 0, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_SETTING) begin
                drain_block(SETTLE_CYCLES);
                write_setting(dir_rows[k].addr, dir_rows[k].data);
            end else begin
                push_sample(dir_rows[k].data, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        phase    = 0;
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            drain_block(SETTLE_CYCLES);
            phase++;
            calm   = (phase % 6 == CALM_PHASE);
            bw     = pick_box();
            bh     = pick_box();
            // one-sample boxes, so every sample closes a box behind the held receiver
            if (phase == HOLD_PHASE) begin
                bw = 1;
                bh = 1;
            end
            fw     = pick_dim();
            fh     = pick_dim();
            mv_val = $urandom_range(1) ? $urandom() : SAMPLE_BITS'($urandom_range(8)) - 4;
            write_setting(REG_BOX_WIDTH, with_noise(bw, BOX_BITS));
            write_setting(REG_BOX_HEIGHT, with_noise(bh, BOX_BITS));
            write_setting(REG_IN_WIDTH, with_noise(fw, DIM_BITS));
            write_setting(REG_IN_HEIGHT, with_noise(fh, DIM_BITS));
            write_setting(REG_MISSING, mv_val);
            if ($urandom_range(9) == 0) begin
                write_setting(CFG_ADDR_BITS'($urandom_range(int'(REG_MISSING) + 1,
                                                            int'(REG_UNUSED))),
                              $urandom());
            end
            area = clip_size(fw, MAX_WIDTH) * clip_size(fh, MAX_WIDTH);
            // mostly whole fields; sometimes cut one short; large fields only partly
            if (area <= 600) begin
                nitems = area * $urandom_range(1, 3);
                if ($urandom_range(4) == 0) begin
                    nitems = $urandom_range(1, 2 * area);
                end
            end else begin
                nitems = $urandom_range(40, 300);
            end
            if (phase == HOLD_PHASE) begin
                nitems       = $urandom_range(60, 200);
                hold_request = 1'b1;
            end
            if (calm && nitems < CALM_ITEMS) begin
                nitems = CALM_ITEMS;
            end
            // keep the total close to the planned item count
            if (nitems > RANDOM_ITEMS - n_random) begin
                nitems = RANDOM_ITEMS - n_random;
            end
            flat = ($urandom_range(3) == 0);
            repeat (nitems) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: smp = $urandom();
                    4, 5:       smp = SAMPLE_BITS'($urandom_range(511)) - 256;
                    6:          smp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default:    smp = mv_val;
                endcase
                if (flat && $urandom_range(99) < 80) begin
                    smp = mv_val;
                end
                push_sample(smp, 1'b0, '0);
            end
            n_random += nitems;
        end

        calm = 1'b0;
        drain_block(TAIL_CYCLES);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
